/* sv/bmcc_pkg.sv */
// ----------------------------------------------------------------------------
// bmcc_pkg: shared definitions for the button multi-click classifier
// Event codes, register map, reset values and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bmcc_pkg;

  // Parameter defaults.
  localparam int unsigned COUNT_MAX_DEF = 15;
  localparam int unsigned TIME_BITS_DEF = 32;

  // Field widths fixed by the interface.
  localparam int unsigned GAP_W        = 16;
  localparam int unsigned NOW_W        = 32;
  localparam int unsigned PRESS_CNT_W  = 4;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned S_TDATA_W    = 40;
  localparam int unsigned M_TDATA_W    = 8;

  // Register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_PRESSED_LEVEL = 2'd0,
    REG_SHORT_HOLD    = 2'd1,
    REG_IDLE_GAP      = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_e;

  // Register reset values.
  localparam logic             PRESSED_LEVEL_RST = 1'b1;
  localparam logic [GAP_W-1:0] SHORT_HOLD_RST    = 16'd500;
  localparam logic [GAP_W-1:0] IDLE_GAP_RST      = 16'd1000;

  // Result kinds.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_COUNT = 2'd1,
    EV_LONG  = 2'd2,
    EV_ERROR = 2'd3
  } event_kind_e;

endpackage

`default_nettype wire

/* sv/button_multi_click_classifier.sv */
// ----------------------------------------------------------------------------
// button_multi_click_classifier: click counting and long-hold detection
// Classifies polled button samples into click counts and long holds.
// ----------------------------------------------------------------------------
// Usage: each slave-side item carries one poll of the button (level plus a
// free-running millisecond timestamp). Every accepted item produces exactly
// one master-side item: the event kind on tuser and the reported press count
// on tdata. Kind "none" items are delivered too, so the output stream is one
// to one with the input stream.
// The result is registered: an accepted item appears on the master side in
// the next cycle. Throughput is one item per cycle while the receiver keeps
// up; the only loop is the classifier state (pressed flag, count, hold flag,
// timestamp), updated by one subtract-and-compare pass in the accepting cycle.
// When the receiver stalls, the result stays in the output register and the
// block still takes a new item in the cycle the held result is taken, so a
// stalled receiver stops the input only while the output register is full
// and not being drained.
// Reset clears the classifier state and the output register and loads the
// register defaults: pressed level high, short hold 500 ms, idle gap 1000 ms.
// The APB port may be written only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module button_multi_click_classifier #(
  parameter int unsigned CountMax = bmcc_pkg::COUNT_MAX_DEF,
  parameter int unsigned TimeBits = bmcc_pkg::TIME_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bmcc_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [bmcc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [bmcc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  // Poll input: tdata = {7'b0, now_ms[31:0], button_level}.
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [bmcc_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // Result output: tdata = {4'b0, press_count[3:0]}, tuser = event_kind[1:0].
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [bmcc_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  output logic      [1:0]                        m_axis_tuser_o
);

  localparam int unsigned CntW = $clog2(CountMax + 1);
  localparam int unsigned GapW = bmcc_pkg::GAP_W;
  localparam int unsigned NowW = bmcc_pkg::NOW_W;
  localparam int unsigned PcW  = bmcc_pkg::PRESS_CNT_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic            pressed_level_q;
  logic [GapW-1:0] short_hold_q;
  logic [GapW-1:0] idle_gap_q;
  logic            cfg_wr;
  logic [1:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_level_q <= bmcc_pkg::PRESSED_LEVEL_RST;
      short_hold_q    <= bmcc_pkg::SHORT_HOLD_RST;
      idle_gap_q      <= bmcc_pkg::IDLE_GAP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bmcc_pkg::REG_PRESSED_LEVEL: pressed_level_q <= pwdata[0];
        bmcc_pkg::REG_SHORT_HOLD:    short_hold_q    <= pwdata[GapW-1:0];
        bmcc_pkg::REG_IDLE_GAP:      idle_gap_q      <= pwdata[GapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bmcc_pkg::REG_PRESSED_LEVEL: prdata = {31'b0, pressed_level_q};
      bmcc_pkg::REG_SHORT_HOLD:    prdata = {16'b0, short_hold_q};
      bmcc_pkg::REG_IDLE_GAP:      prdata = {16'b0, idle_gap_q};
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: accept whenever the output register is empty or being drained.
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic s_accept;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Classifier state and next-state logic
  // --------------------------------------------------------------------------
  logic                was_pressed_q, was_pressed_d;
  logic [CntW-1:0]     click_cnt_q,   click_cnt_d;
  logic                long_hold_q,   long_hold_d;
  logic [TimeBits-1:0] last_time_q,   last_time_d;

  logic                      button_level;
  logic [NowW-1:0]           now_ms;
  logic [TimeBits+NowW-1:0]  now_wide;
  logic [TimeBits-1:0]       now_t;
  logic [TimeBits-1:0]       delta;
  logic                      pressed_now;
  logic                      over_gap;
  logic                      over_short;
  logic                      bad_state;
  bmcc_pkg::event_kind_e     kind_d;
  logic [CntW-1:0]           rep_cnt_d;

  assign button_level = s_axis_tdata_i[0];
  assign now_ms       = s_axis_tdata_i[NowW:1];
  // Time is kept modulo 2^TimeBits; a 32-bit stamp is widened or cut to fit.
  assign now_wide     = {{TimeBits{1'b0}}, now_ms};
  assign now_t        = now_wide[TimeBits-1:0];
  assign delta        = now_t - last_time_q;
  assign pressed_now  = (button_level == pressed_level_q);
  assign over_gap     = delta > TimeBits'(idle_gap_q);
  assign over_short   = delta > TimeBits'(short_hold_q);
  assign bad_state    = (!was_pressed_q && long_hold_q) ||
                        (was_pressed_q && !long_hold_q && (click_cnt_q == '0));

  always_comb begin
    was_pressed_d = was_pressed_q;
    click_cnt_d   = click_cnt_q;
    long_hold_d   = long_hold_q;
    last_time_d   = last_time_q;
    kind_d        = bmcc_pkg::EV_NONE;
    rep_cnt_d     = '0;

    if (bad_state) begin
      // Inconsistent state is reported and leaves everything untouched.
      kind_d = bmcc_pkg::EV_ERROR;
    end else if (was_pressed_q) begin
      if (pressed_now) begin
        if (long_hold_q) begin
          kind_d = bmcc_pkg::EV_LONG;
        end else if (over_gap) begin
          long_hold_d = 1'b1;
          click_cnt_d = '0;
          kind_d      = bmcc_pkg::EV_LONG;
        end
      end else begin
        was_pressed_d = 1'b0;
        last_time_d   = now_t;
        if (long_hold_q) begin
          // The release that ends a long hold reports nothing.
          long_hold_d = 1'b0;
          click_cnt_d = '0;
        end else if (over_short) begin
          click_cnt_d = '0;
          if (click_cnt_q != '0) begin
            kind_d    = bmcc_pkg::EV_COUNT;
            rep_cnt_d = click_cnt_q;
          end
        end
      end
    end else begin
      if (pressed_now) begin
        if (click_cnt_q < CntW'(CountMax)) begin
          click_cnt_d = click_cnt_q + CntW'(1);
        end
        was_pressed_d = 1'b1;
        last_time_d   = now_t;
      end else if (over_gap) begin
        // End of a click sequence after a quiet idle gap.
        last_time_d = now_t;
        click_cnt_d = '0;
        if (click_cnt_q != '0) begin
          kind_d    = bmcc_pkg::EV_COUNT;
          rep_cnt_d = click_cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_pressed_q <= 1'b0;
      click_cnt_q   <= '0;
      long_hold_q   <= 1'b0;
      last_time_q   <= '0;
    end else if (s_accept) begin
      was_pressed_q <= was_pressed_d;
      click_cnt_q   <= click_cnt_d;
      long_hold_q   <= long_hold_d;
      last_time_q   <= last_time_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  bmcc_pkg::event_kind_e  out_kind_q;
  logic [PcW-1:0]         out_cnt_q;
  logic [CntW+PcW-1:0]    rep_cnt_wide;

  // The reported count carries the low four bits of the saturating counter.
  assign rep_cnt_wide = {{PcW{1'b0}}, rep_cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_kind_q <= kind_d;
      out_cnt_q  <= rep_cnt_wide[PcW-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(bmcc_pkg::M_TDATA_W-PcW){1'b0}}, out_cnt_q};
  assign m_axis_tuser_o  = out_kind_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // A long hold is only ever entered while pressed, and it clears the count.
  a_long_hold_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_hold_q |-> (was_pressed_q && (click_cnt_q == '0)))
    else $error("long hold flag set with inconsistent press state");

  // The press counter saturates and never runs past its maximum.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    click_cnt_q <= CntW'(CountMax))
    else $error("click counter exceeded its maximum");

  // Every accepted poll yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> out_valid_q)
    else $error("accepted item produced no result");

  // With CountMax up to 15, a reported count is never empty; other kinds carry none.
  a_count_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_kind_q == bmcc_pkg::EV_COUNT) == (out_cnt_q != '0)) ||
                    (CountMax > 15))
    else $error("press count does not match event kind");
`endif

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the button multi-click classifier
// Streams button polls into the block, predicts every result item from a
// behavioral model of the classifier, and checks each item the block sends
// against the oldest prediction. The register settings are changed between
// phases, and both stream sides idle at random in all but the last phase.
// ----------------------------------------------------------------------------

module testbench;

  // One poll of the button as it travels on the input stream.
  typedef struct {
    logic        level;
    logic [31:0] now;
  } poll_t;

  // One classification result as it travels on the output stream.
  typedef struct {
    bmcc_pkg::event_kind_e kind;
    logic [3:0]            count;
  } click_event_t;

  localparam int unsigned TIMEOUT_NS = 2_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // APB side, idle from the start.
  logic                            psel    = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite  = 1'b0;
  logic [bmcc_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [bmcc_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [bmcc_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // Stream sides.
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [bmcc_pkg::S_TDATA_W-1:0] s_tdata  = '0;  // {7'b0, now_ms[31:0], button_level}
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [bmcc_pkg::M_TDATA_W-1:0] m_tdata;        // {4'b0, press_count[3:0]}
  logic [1:0]                     m_tuser;        // event_kind[1:0]

  // Polls waiting to be offered, and results waiting to arrive.
  poll_t        poll_backlog[$];
  click_event_t pending_events[$];

  int unsigned polls_queued   = 0;
  int unsigned polls_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned settings_used  = 1;
  int unsigned kind_seen[4]   = '{0, 0, 0, 0};
  bit          poll_taken     = 1'b0;

  // Percentage of cycles in which each side holds back.
  int unsigned feed_idle_pct  = 33;
  int unsigned drain_idle_pct = 72;

  // Register copies, kept in step with every APB write.
  logic                       cfg_pressed_level = bmcc_pkg::PRESSED_LEVEL_RST;
  logic [bmcc_pkg::GAP_W-1:0] cfg_short_hold    = bmcc_pkg::SHORT_HOLD_RST;
  logic [bmcc_pkg::GAP_W-1:0] cfg_idle_gap      = bmcc_pkg::IDLE_GAP_RST;

  // Classifier state as the block should hold it.
  bit          btn_down       = 1'b0;
  int unsigned clicks         = 0;
  bit          long_hold      = 1'b0;
  logic [31:0] last_change_ms = '0;

  // Running timestamp used by the sequence generator; it wraps like the real one.
  logic [31:0] gen_ms = '0;

  button_multi_click_classifier i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Works out the result of one accepted poll and advances the classifier state.
  function automatic void classify_poll(input logic level, input logic [31:0] now);
    logic         pressed_now;
    logic [31:0]  elapsed;
    click_event_t ev;
    pressed_now = (level == cfg_pressed_level);
    elapsed     = now - last_change_ms;  // wraps modulo 2^32 by width
    ev.kind     = bmcc_pkg::EV_NONE;
    ev.count    = '0;
    if ((!btn_down && long_hold) || (btn_down && !long_hold && clicks == 0)) begin
      // An inconsistent state answers with an error and leaves everything as it is.
      ev.kind = bmcc_pkg::EV_ERROR;
    end else if (btn_down) begin
      if (pressed_now) begin
        if (long_hold) begin
          ev.kind = bmcc_pkg::EV_LONG;
        end else if (elapsed > cfg_idle_gap) begin
          long_hold = 1'b1;
          clicks    = 0;
          ev.kind   = bmcc_pkg::EV_LONG;
        end
      end else begin
        btn_down       = 1'b0;
        last_change_ms = now;
        if (long_hold) begin
          // Releasing after a long hold reports nothing.
          long_hold = 1'b0;
          clicks    = 0;
        end else if (elapsed > cfg_short_hold) begin
          if (clicks != 0) begin
            ev.kind  = bmcc_pkg::EV_COUNT;
            ev.count = clicks[3:0];
          end
          clicks = 0;
        end
      end
    end else if (pressed_now) begin
      if (clicks < bmcc_pkg::COUNT_MAX_DEF) clicks++;
      btn_down       = 1'b1;
      last_change_ms = now;
    end else if (elapsed > cfg_idle_gap) begin
      // End of a click sequence; an empty count reports nothing.
      last_change_ms = now;
      if (clicks != 0) begin
        ev.kind  = bmcc_pkg::EV_COUNT;
        ev.count = clicks[3:0];
      end
      clicks = 0;
    end
    pending_events.push_back(ev);
  endfunction

  // Input side: offer a new poll at the falling edge once the last one was taken.
  always @(negedge clk) begin
    poll_t p;
    if (!rst_n) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || poll_taken) begin
      if (poll_backlog.size() != 0 && $urandom_range(99) >= feed_idle_pct) begin
        p = poll_backlog.pop_front();
        s_tdata  <= {7'b0, p.now, p.level};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    poll_taken = 1'b0;
    m_tready <= ($urandom_range(99) >= drain_idle_pct);
  end

  // A poll is accepted at the rising edge; predict its result right away.
  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_tready) begin
      classify_poll(s_tdata[0], s_tdata[32:1]);
      polls_accepted++;
      poll_taken = 1'b1;
    end
  end

  // Output side: compare each delivered item with the oldest prediction.
  always @(posedge clk) begin
    click_event_t want;
    if (rst_n && m_tvalid && m_tready) begin
      results_seen++;
      kind_seen[m_tuser]++;
      if (pending_events.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual kind %0d count %0d",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_events.pop_front();
        if (m_tuser !== want.kind || m_tdata !== {4'b0, want.count}) begin
          fail_count++;
          $display("%0t: mismatch, expected kind %0d count %0d, actual kind %0d tdata %0d",
                   $time, want.kind, want.count, m_tuser, m_tdata);
        end
      end
    end
  end

  // Queues one poll; the level is chosen from the current pressed level.
  task automatic add_poll(input bit pressed, input logic [31:0] now);
    poll_t p;
    p.level = pressed ? cfg_pressed_level : ~cfg_pressed_level;
    p.now   = now;
    poll_backlog.push_back(p);
    polls_queued++;
  endtask

  // A time step that lands on, just past, below, or up to 50 past a threshold.
  function automatic int unsigned gap_near(input int unsigned limit);
    case ($urandom_range(3))
      0:       return limit;
      1:       return limit + 1;
      2:       return (limit > 0) ? $urandom_range(limit - 1) : 0;
      default: return limit + $urandom_range(50);
    endcase
  endfunction

  // Several clicks in a row, then quiet polls that close the sequence.
  task automatic queue_click_burst(input int unsigned presses);
    for (int i = 0; i < presses; i++) begin
      gen_ms += (i == 0) ? gap_near(cfg_idle_gap) : $urandom_range(cfg_idle_gap);
      add_poll(1'b1, gen_ms);
      if (presses < 8 && $urandom_range(3) == 0) begin
        gen_ms += $urandom_range(cfg_idle_gap);
        add_poll(1'b1, gen_ms);
      end
      // Only the last press may outlast the short hold in bursts of eight or more, so long bursts saturate.
      gen_ms += (i == presses - 1) ? gap_near(cfg_short_hold) : $urandom_range(cfg_short_hold);
      add_poll(1'b0, gen_ms);
      if ($urandom_range(4) == 0) begin
        gen_ms += $urandom_range(cfg_idle_gap);
        add_poll(1'b0, gen_ms);
      end
    end
    gen_ms += gap_near(cfg_idle_gap);
    add_poll(1'b0, gen_ms);
    if ($urandom_range(1) == 0) begin
      gen_ms += cfg_idle_gap + 1;
      add_poll(1'b0, gen_ms);
    end
  endtask

  // A press held for about the idle gap, one to three more held polls, then the release.
  task automatic queue_long_hold();
    gen_ms += gap_near(cfg_idle_gap);
    add_poll(1'b1, gen_ms);
    gen_ms += gap_near(cfg_idle_gap);
    add_poll(1'b1, gen_ms);
    repeat ($urandom_range(1, 3)) begin
      gen_ms += $urandom_range(2000);
      add_poll(1'b1, gen_ms);
    end
    gen_ms += $urandom_range(100);
    add_poll(1'b0, gen_ms);
  endtask

  // Mostly well-formed click and hold sequences, with some noise and time jumps.
  task automatic queue_random_polls(input int unsigned target);
    int unsigned first;
    first = polls_queued;
    while (polls_queued - first < target) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          queue_click_burst(($urandom_range(7) == 0) ? $urandom_range(15, 18)
                                                     : $urandom_range(1, 4));
        end
        6, 7: queue_long_hold();
        8: begin
          repeat ($urandom_range(1, 4)) add_poll(1'($urandom_range(1)), $urandom());
        end
        default: begin
          // Jump close to the wrap point of the timestamp, or anywhere.
          gen_ms = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000)
                                            : $urandom();
          add_poll(1'($urandom_range(1)), gen_ms);
        end
      endcase
    end
  endtask

  // Returns once every queued poll was taken and every result has arrived.
  task automatic wait_drained();
    while (polls_accepted != polls_queued || pending_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input bmcc_pkg::reg_idx_e idx,
                           input logic [bmcc_pkg::APB_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      bmcc_pkg::REG_PRESSED_LEVEL: cfg_pressed_level = value[0];
      bmcc_pkg::REG_SHORT_HOLD:    cfg_short_hold    = value[bmcc_pkg::GAP_W-1:0];
      bmcc_pkg::REG_IDLE_GAP:      cfg_idle_gap      = value[bmcc_pkg::GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_settings(input logic level, input int unsigned short_ms,
                                input int unsigned idle_ms);
    write_reg(bmcc_pkg::REG_PRESSED_LEVEL, {31'b0, level});
    write_reg(bmcc_pkg::REG_SHORT_HOLD, short_ms);
    write_reg(bmcc_pkg::REG_IDLE_GAP, idle_ms);
    settings_used++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed polls under the reset settings: quiet polls at and past the
    // idle gap, a triple click, a hold crossing the idle gap, releases at and
    // past the short hold, and press/release pairs across the timestamp wrap.
    add_poll(1'b0, 32'd0);
    add_poll(1'b0, 32'd1001);
    add_poll(1'b1, 32'd1010);
    add_poll(1'b0, 32'd1020);
    add_poll(1'b1, 32'd1030);
    add_poll(1'b0, 32'd1040);
    add_poll(1'b1, 32'd1050);
    add_poll(1'b0, 32'd1551);
    add_poll(1'b1, 32'd1600);
    add_poll(1'b1, 32'd2600);
    add_poll(1'b1, 32'd2601);
    add_poll(1'b1, 32'd2602);
    add_poll(1'b0, 32'd2700);
    add_poll(1'b0, 32'd3701);
    add_poll(1'b0, 32'hFFFF_FF00);
    add_poll(1'b1, 32'hFFFF_FFF0);
    add_poll(1'b0, 32'h0000_0100);
    add_poll(1'b0, 32'h0000_04E8);
    add_poll(1'b1, 32'hFFFF_FFFF);
    add_poll(1'b0, 32'h0000_01F3);
    add_poll(1'b0, 32'h0000_05DC);
    gen_ms = 32'h0000_05DC;
    wait_drained();

    // Active-low button, zero short hold, longest idle gap.
    write_settings(1'b0, 0, 65535);
    queue_random_polls(130);
    wait_drained();

    // Roles of the two sides swapped; longest short hold, zero idle gap.
    feed_idle_pct  = 72;
    drain_idle_pct = 33;
    write_settings(1'b1, 65535, 0);
    queue_random_polls(130);
    wait_drained();

    // Full rate on both sides with moderate settings; one burst long enough
    // to saturate the press count.
    feed_idle_pct  = 0;
    drain_idle_pct = 0;
    write_settings(1'($urandom_range(1)), $urandom_range(20, 200), $urandom_range(250, 400));
    queue_click_burst(18);
    queue_random_polls(130);
    wait_drained();

    $display("Ran %0d polls under %0d register settings, %0d results checked.",
             polls_accepted, settings_used, results_seen);
    $display("Results by kind: none %0d, count %0d, long hold %0d, error %0d.",
             kind_seen[bmcc_pkg::EV_NONE], kind_seen[bmcc_pkg::EV_COUNT],
             kind_seen[bmcc_pkg::EV_LONG], kind_seen[bmcc_pkg::EV_ERROR]);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d of %0d polls taken, %0d results outstanding.",
             polls_accepted, polls_queued, pending_events.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
